FILE: rtl/mmh_pkg.sv
// MurmurHash64A engine: shared types, constants and helper functions.
// No dependencies; every other file in rtl/ but mmh_checker imports this package.
package mmh_pkg;

   localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
   localparam int          MIX_SHIFT  = 47;
   localparam logic [63:0] SEED_RESET = 64'd123;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_MUL_LEN,
      ST_DISPATCH,
      ST_MUL_K1,
      ST_MUL_K2,
      ST_MUL_H,
      ST_FINISH,
      ST_MUL_AVAL,
      ST_EMIT
   } state_type;

   // operand fed to the multiplier on a start
   typedef enum logic [2:0] {
      SRC_LEN,    // zero-extended total length
      SRC_WORD,   // raw key word
      SRC_K,      // product xor-shifted by 47
      SRC_HK,     // work hash xor product
      SRC_TAIL,   // work hash xor masked tail bytes
      SRC_AVAL    // work hash xor-shifted by 47
   } mul_src_type;

   typedef enum logic [1:0] {
      W_HOLD,
      W_HASH,     // continue from running hash
      W_SEED,     // seed xor product
      W_PROD      // product
   } w_op_type;

   typedef enum logic [1:0] {
      H_HOLD,
      H_SAVE,
      H_CLEAR
   } h_op_type;

   typedef struct packed {
      logic        load;
      logic        mul_start;
      mul_src_type mul_src;
      w_op_type    w_op;
      h_op_type    h_op;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic first;
      logic last;
      logic full;
      logic empty;
      logic mul_done;
   } dp_status_type;

   // low-byte mask for a tail of n bytes (n = 1..7)
   function automatic logic [63:0] tail_mask(input logic [2:0] n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         m[i*8 +: 8] = (i < int'(n)) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

endpackage

FILE: rtl/murmur_hash_64a.sv
// Top level of the streaming MurmurHash64A engine.
// Depends on mmh_pkg, mmh_ctrl and mmh_datapath.
//
// Usage: a key streams in as little-endian 64-bit words on the req_ channel,
// first key byte in bits 7..0. Mark the first word with req_first_word (its
// req_total_length seeds the hash as seed ^ length*M) and the final word with
// req_last_word; one hash comes out on the rsp_ channel per key. A word with
// req_valid_bytes of 8 or more is mixed as a full word, 1..7 as a tail, 0 adds
// nothing (use it for an empty key). Each 64-bit multiply by the mix constant
// runs on one shared 32x32 multiplier in three passes, and that sets the
// rate: one transaction at a time, a full word needing three multiplies and a
// tail word one, an empty word none; a first word adds the length multiply
// and a last word the avalanche multiply and handoff. A finished hash sits in
// the output register, so the next transaction is taken while it waits; only
// a following last word stalls on it. The seed register (csr_, reset value
// 123) is always ready and should be written only while no key is in flight.
module murmur_hash_64a (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_first_word,
   input  logic        req_last_word,
   input  logic [31:0] req_total_length,
   // hash results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash_value,
   // seed register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_hash_seed
);
   import mmh_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   mmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mmh_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .data_word    (req_data_word),
      .valid_bytes  (req_valid_bytes),
      .first_word   (req_first_word),
      .last_word    (req_last_word),
      .total_length (req_total_length),
      .seed_write   (csr_valid && csr_ready),
      .seed_value   (csr_hash_seed),
      .hash_value   (rsp_hash_value)
   );

endmodule

FILE: rtl/mmh_mul.sv
// Multi-cycle 64x64 (low 64 bits) multiply by the mix constant.
// One shared 32x32 multiplier, three passes. Depends on mmh_pkg.
module mmh_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] operand,
   output logic        done,
   output logic [63:0] product
);
   import mmh_pkg::*;

   localparam logic [1:0] STEP_LAST = 2'd2;

   logic        busy_ff, busy_in;
   logic [1:0]  step_ff, step_in;
   logic        done_ff, done_in;
   logic [63:0] a_ff;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] mx, my;
   logic [63:0] prod;

   always_comb begin
      case (step_ff)
         2'd0: begin
            mx = a_ff[31:0];
            my = MIX_MUL[31:0];
         end
         2'd1: begin
            mx = a_ff[31:0];
            my = MIX_MUL[63:32];
         end
         default: begin
            mx = a_ff[63:32];
            my = MIX_MUL[31:0];
         end
      endcase
      prod = {32'b0, mx} * {32'b0, my};
      // cross terms only reach the upper half
      if (step_ff == 2'd0) acc_in = prod;
      else                 acc_in = acc_ff + {prod[31:0], 32'b0};
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = busy_ff && (step_ff == STEP_LAST);
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         if (step_ff == STEP_LAST) busy_in = 1'b0;
         else                      step_in = step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start)   a_ff   <= operand;
      if (busy_ff) acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

FILE: rtl/mmh_datapath.sv
// Datapath: input capture, seed register, work/running hash, multiplier, output.
// Depends on mmh_pkg and mmh_mul.
module mmh_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  mmh_pkg::dp_cmd_type   cmd,
   output mmh_pkg::dp_status_type status,
   input  logic [63:0]           data_word,
   input  logic [3:0]            valid_bytes,
   input  logic                  first_word,
   input  logic                  last_word,
   input  logic [31:0]           total_length,
   input  logic                  seed_write,
   input  logic [63:0]           seed_value,
   output logic [63:0]           hash_value
);
   import mmh_pkg::*;

   logic [63:0] word_ff;
   logic [3:0]  nbytes_ff;
   logic        first_ff, last_ff;
   logic [31:0] len_ff;
   logic [63:0] seed_ff;
   logic [63:0] hash_ff;
   logic [63:0] w_ff;
   logic [63:0] out_ff;
   logic [63:0] mul_a;
   logic [63:0] prod;
   logic        mul_done;

   always_comb begin
      case (cmd.mul_src)
         SRC_LEN:  mul_a = {32'b0, len_ff};
         SRC_WORD: mul_a = word_ff;
         SRC_K:    mul_a = prod ^ (prod >> MIX_SHIFT);
         SRC_HK:   mul_a = w_ff ^ prod;
         SRC_TAIL: mul_a = w_ff ^ (word_ff & tail_mask(nbytes_ff[2:0]));
         SRC_AVAL: mul_a = w_ff ^ (w_ff >> MIX_SHIFT);
         default:  mul_a = word_ff;
      endcase
   end

   mmh_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .operand (mul_a),
      .done    (mul_done),
      .product (prod)
   );

   // seed and running hash carry reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
         hash_ff <= '0;
      end else begin
         if (seed_write) seed_ff <= seed_value;
         case (cmd.h_op)
            H_SAVE:  hash_ff <= w_ff;
            H_CLEAR: hash_ff <= '0;
            default: hash_ff <= hash_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff   <= data_word;
         nbytes_ff <= valid_bytes;
         first_ff  <= first_word;
         last_ff   <= last_word;
         len_ff    <= total_length;
      end
      case (cmd.w_op)
         W_HASH:  w_ff <= hash_ff;
         W_SEED:  w_ff <= seed_ff ^ prod;
         W_PROD:  w_ff <= prod;
         default: w_ff <= w_ff;
      endcase
      if (cmd.out_load) out_ff <= prod ^ (prod >> MIX_SHIFT);
   end

   // counts 9..15 act as a full word
   assign status.first    = first_ff;
   assign status.last     = last_ff;
   assign status.full     = nbytes_ff[3];
   assign status.empty    = (nbytes_ff == 4'd0);
   assign status.mul_done = mul_done;
   assign hash_value      = out_ff;

endmodule

FILE: rtl/mmh_ctrl.sv
// Controller FSM: sequences load, multiplies, hash updates and result handoff.
// Depends on mmh_pkg.
module mmh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mmh_pkg::dp_status_type status,
   output mmh_pkg::dp_cmd_type    cmd
);
   import mmh_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      req_ready     = 1'b0;
      cmd.load      = 1'b0;
      cmd.mul_start = 1'b0;
      cmd.mul_src   = SRC_WORD;
      cmd.w_op      = W_HOLD;
      cmd.h_op      = H_HOLD;
      cmd.out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.first) begin
               cmd.mul_start = 1'b1;
               cmd.mul_src   = SRC_LEN;
               state_in      = ST_MUL_LEN;
            end else begin
               cmd.w_op = W_HASH;
               state_in = ST_DISPATCH;
            end
         end
         ST_MUL_LEN: begin
            if (status.mul_done) begin
               cmd.w_op = W_SEED;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.full) begin
               cmd.mul_start = 1'b1;
               cmd.mul_src   = SRC_WORD;
               state_in      = ST_MUL_K1;
            end else if (status.empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_src   = SRC_TAIL;
               state_in      = ST_MUL_H;
            end
         end
         ST_MUL_K1: begin
            if (status.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.mul_src   = SRC_K;
               state_in      = ST_MUL_K2;
            end
         end
         ST_MUL_K2: begin
            if (status.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.mul_src   = SRC_HK;
               state_in      = ST_MUL_H;
            end
         end
         ST_MUL_H: begin
            if (status.mul_done) begin
               cmd.w_op = W_PROD;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.last) begin
               cmd.mul_start = 1'b1;
               cmd.mul_src   = SRC_AVAL;
               state_in      = ST_MUL_AVAL;
            end else begin
               cmd.h_op = H_SAVE;
               state_in = ST_IDLE;
            end
         end
         ST_MUL_AVAL: begin
            if (status.mul_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // product holds until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               cmd.h_op     = H_CLEAR;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/mmh_checker.sv
// Port-level assertions for murmur_hash_64a, bound to the top level.
// Depends on murmur_hash_64a's port list only.
module mmh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_hash_value,
   input logic        csr_ready
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value))
      else $error("result changed or dropped while stalled");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again right after a transaction");

   // no result rises directly after a word is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result appeared directly after a transaction");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("seed register not ready");

endmodule

bind murmur_hash_64a mmh_checker u_mmh_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hash_value (rsp_hash_value),
   .csr_ready      (csr_ready)
);
